### design/rrla_pkg.sv
// ----------------------------------------------------------------------------
// rrla_pkg
// Shared types and sizing for the round-robin lease arbiter.
// ----------------------------------------------------------------------------
package rrla_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = KEY_W + TIME_W;

    localparam logic [TIME_W-1:0] MAX_WAIT_RESET = TIME_W'(60);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_GET     = 2'd1,
        OP_TOUCH   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NONE      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_INVALID   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // operands for the shared compare unit
    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  max_wait;
        logic [KEY_W-1:0]   ent_key;
        logic [TIME_W-1:0]  ent_stamp;
    } match_req_t;

endpackage

### design/round_robin_lease_arbiter_core.sv
// Add of key zero, and any request on an empty table, skip the table walk. An
//   add scans for duplicates and then shifts the entries from head up one slot.
// Get, touch and release walk the occupied entries through the entry memory
//   (one read port, one write port), one entry per cycle.
// One transfer in flight at a time; the next input is taken once the result
//   is registered. Reset empties the table, head 0, max_wait 60.
// ----------------------------------------------------------------------------
// round_robin_lease_arbiter_core
// Top level: max_wait register and the arbiter sequencer.
// ----------------------------------------------------------------------------
module round_robin_lease_arbiter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rrla_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [rrla_pkg::KEY_W-1:0]  key,
    input  logic [rrla_pkg::TIME_W-1:0] now,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [rrla_pkg::KEY_W-1:0]  granted_key
);

    logic [rrla_pkg::TIME_W-1:0] max_wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wait_reg <= rrla_pkg::MAX_WAIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_wait_reg <= cfg_wr_data;
        end
    end

    rrla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .key         (key),
        .now         (now),
        .max_wait    (max_wait_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .granted_key (granted_key)
    );

endmodule

### design/rrla_match.sv
// ----------------------------------------------------------------------------
// rrla_match
// Shared compare unit: key equality for add/touch/release, rest-time check
// (now - stamp > max_wait, modulo 2^32) for get.
// ----------------------------------------------------------------------------
module rrla_match (
    input  rrla_pkg::match_req_t req,
    output logic                 hit
);

    logic [rrla_pkg::TIME_W-1:0] rest;
    logic                        eligible;
    logic                        key_eq;

    assign rest     = req.now - req.ent_stamp;
    assign eligible = rest > req.max_wait;
    assign key_eq   = req.ent_key == req.key;
    assign hit      = (req.op == rrla_pkg::OP_GET) ? eligible : key_eq;

endmodule

### design/rrla_ctrl.sv
// ----------------------------------------------------------------------------
// rrla_ctrl
// Sequencer, entry table and result register. Walks the ring one entry per
// cycle through the shared compare unit; inserts by shifting entries up.
// ----------------------------------------------------------------------------
module rrla_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [rrla_pkg::KEY_W-1:0]  key,
    input  logic [rrla_pkg::TIME_W-1:0] now,
    input  logic [rrla_pkg::TIME_W-1:0] max_wait,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [rrla_pkg::KEY_W-1:0]  granted_key
);

    localparam int IDX_W   = rrla_pkg::IDX_W;
    localparam int CNT_W   = rrla_pkg::CNT_W;
    localparam int KEY_W   = rrla_pkg::KEY_W;
    localparam int TIME_W  = rrla_pkg::TIME_W;
    localparam int ENTRY_W = rrla_pkg::ENTRY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_INSERT,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    rrla_pkg::op_t          op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       iss_idx_reg, iss_idx_next;
    logic [CNT_W-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   chk_last_reg, chk_last_next;
    logic                   shift_on_reg, shift_on_next;
    rrla_pkg::status_t      res_status_reg, res_status_next;
    logic [KEY_W-1:0]       res_key_reg, res_key_next;
    logic                   out_valid_reg, out_valid_next;
    rrla_pkg::status_t      out_status_reg, out_status_next;
    logic [KEY_W-1:0]       out_key_reg, out_key_next;

    // entry table: {key, stamp}
    logic [ENTRY_W-1:0]     mem [rrla_pkg::MAX_ENTRIES];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;

    logic [KEY_W-1:0]       rd_key;
    logic [TIME_W-1:0]      rd_stamp;
    rrla_pkg::match_req_t   mreq;
    logic                   hit;
    logic [IDX_W-1:0]       chk_idx_inc;
    logic                   chk_at_end;
    logic                   iss_at_end;

    assign rd_key   = rd_data_reg[ENTRY_W-1:TIME_W];
    assign rd_stamp = rd_data_reg[TIME_W-1:0];

    assign mreq.op        = op_reg;
    assign mreq.key       = key_reg;
    assign mreq.now       = now_reg;
    assign mreq.max_wait  = max_wait;
    assign mreq.ent_key   = rd_key;
    assign mreq.ent_stamp = rd_stamp;

    rrla_match u_match (
        .req (mreq),
        .hit (hit)
    );

    assign chk_idx_inc = chk_idx_reg + IDX_W'(1);
    assign chk_at_end  = (CNT_W'(chk_idx_reg) == count_reg - CNT_W'(1));
    assign iss_at_end  = (CNT_W'(iss_idx_reg) == count_reg - CNT_W'(1));

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign granted_key = out_key_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        iss_idx_next    = iss_idx_reg;
        iss_cnt_next    = iss_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        chk_last_next   = chk_last_reg;
        shift_on_next   = shift_on_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        mem_re          = 1'b0;
        mem_raddr       = iss_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_idx_reg;
        mem_wdata       = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = rrla_pkg::op_t'(operation);
                    key_next        = key;
                    now_next        = now;
                    res_key_next    = '0;
                    iss_idx_next    = head_reg;
                    iss_cnt_next    = '0;
                    if (rrla_pkg::op_t'(operation) == rrla_pkg::OP_ADD && key == '0)
                    begin
                        res_status_next = rrla_pkg::ST_INVALID;
                        state_next      = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        if (rrla_pkg::op_t'(operation) == rrla_pkg::OP_ADD)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            res_status_next = rrla_pkg::ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (chk_vld_reg && hit)
                begin
                    state_next      = S_FINISH;
                    res_status_next = rrla_pkg::ST_OK;
                    mem_waddr       = chk_idx_reg;
                    case (op_reg)
                        rrla_pkg::OP_GET:
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = {rd_key, now_reg};
                            res_key_next = rd_key;
                            head_next    = chk_at_end ? '0 : chk_idx_inc;
                        end
                        rrla_pkg::OP_TOUCH:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {rd_key, now_reg};
                        end
                        rrla_pkg::OP_RELEASE:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {rd_key, {TIME_W{1'b0}}};
                        end
                        default:
                        begin
                            res_status_next = rrla_pkg::ST_INVALID;
                        end
                    endcase
                end
                else if (chk_vld_reg && chk_last_reg)
                begin
                    state_next = S_FINISH;
                    case (op_reg)
                        rrla_pkg::OP_GET:
                        begin
                            res_status_next = rrla_pkg::ST_NONE;
                        end
                        rrla_pkg::OP_ADD:
                        begin
                            if (count_reg == CNT_W'(rrla_pkg::MAX_ENTRIES))
                            begin
                                res_status_next = rrla_pkg::ST_FULL;
                            end
                            else
                            begin
                                // move head..count-1 up one slot, top first
                                state_next    = S_SHIFT;
                                iss_idx_next  = IDX_W'(count_reg - CNT_W'(1));
                                shift_on_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = rrla_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
                else if (iss_cnt_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = iss_idx_reg;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = iss_idx_reg;
                    chk_last_next = (iss_cnt_reg == count_reg - CNT_W'(1));
                    iss_idx_next  = iss_at_end ? '0 : iss_idx_reg + IDX_W'(1);
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                if (chk_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_inc;
                    mem_wdata = rd_data_reg;
                    if (chk_idx_reg == head_reg)
                    begin
                        state_next = S_INSERT;
                    end
                end
                if (shift_on_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = iss_idx_reg;
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_idx_reg;
                    if (iss_idx_reg == head_reg)
                    begin
                        shift_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_idx_next = iss_idx_reg - IDX_W'(1);
                    end
                end
            end

            S_INSERT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = head_reg;
                mem_wdata       = {key_reg, {TIME_W{1'b0}}};
                count_next      = count_reg + CNT_W'(1);
                res_status_next = rrla_pkg::ST_OK;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_key_next    = res_key_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            shift_on_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= rrla_pkg::OP_ADD;
            res_status_reg <= rrla_pkg::ST_OK;
            out_status_reg <= rrla_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            chk_vld_reg    <= chk_vld_next;
            shift_on_reg   <= shift_on_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
            res_status_reg <= res_status_next;
            out_status_reg <= out_status_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        now_reg      <= now_next;
        iss_idx_reg  <= iss_idx_next;
        iss_cnt_reg  <= iss_cnt_next;
        chk_idx_reg  <= chk_idx_next;
        chk_last_reg <= chk_last_next;
        res_key_reg  <= res_key_next;
        out_key_reg  <= out_key_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(rrla_pkg::MAX_ENTRIES))
        else $error("entry count above table size");

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(head_reg) < count_reg))
        else $error("head outside occupied ring");

    a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("head nonzero on empty table");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_key_reg == '0 || out_status_reg == rrla_pkg::ST_OK))
        else $error("granted key with failing status");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for round_robin_lease_arbiter_core: directed corner
// requests, then random add/get/touch/release traffic over a small key pool
// across several max_wait settings, checked against a behavioral ring model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int POOL_SIZE     = 20;
    localparam int PHASE_ITEMS   = 270;
    localparam int NUM_PHASES    = 7;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 2 * rrla_pkg::MAX_ENTRIES + 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        rrla_pkg::status_t                status;
        logic [rrla_pkg::KEY_W-1:0]       granted;
    } lease_result_t;

    // Ring model of the arbiter plus the queue of results still owed by the block.
    class lease_scoreboard;
        logic [rrla_pkg::KEY_W-1:0]  ring_keys [rrla_pkg::MAX_ENTRIES];
        logic [rrla_pkg::TIME_W-1:0] ring_stamps [rrla_pkg::MAX_ENTRIES];
        int                          held;
        int                          head;
        logic [rrla_pkg::TIME_W-1:0] rest_limit;
        lease_result_t               pending_results [$];
        int                          fail_count;

        function new();
            held       = 0;
            head       = 0;
            rest_limit = rrla_pkg::MAX_WAIT_RESET;
            fail_count = 0;
        endfunction

        function int find_key(logic [rrla_pkg::KEY_W-1:0] k);
            int i;
            for (i = 0; i < held; i++)
            begin
                if (ring_keys[i] == k)
                    return i;
            end
            return -1;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_request(rrla_pkg::op_t op, logic [rrla_pkg::KEY_W-1:0] k,
                                   logic [rrla_pkg::TIME_W-1:0] t);
            lease_result_t               r;
            logic [rrla_pkg::TIME_W-1:0] age;
            int                          slot;
            int                          idx;
            int                          i;
            r.status  = rrla_pkg::ST_OK;
            r.granted = '0;
            if (op == rrla_pkg::OP_ADD)
            begin
                slot = find_key(k);
                if (k == '0 || slot >= 0)
                    r.status = rrla_pkg::ST_INVALID;
                else if (held >= rrla_pkg::MAX_ENTRIES)
                    r.status = rrla_pkg::ST_FULL;
                else
                begin
                    if (head >= held)
                        head = 0;
                    // open a slot at the head; the new key becomes the head
                    for (i = held; i > head; i--)
                    begin
                        ring_keys[i]   = ring_keys[i-1];
                        ring_stamps[i] = ring_stamps[i-1];
                    end
                    ring_keys[head]   = k;
                    ring_stamps[head] = '0;
                    held++;
                end
            end
            else if (held == 0)
                r.status = rrla_pkg::ST_EMPTY;
            else if (op == rrla_pkg::OP_GET)
            begin
                r.status = rrla_pkg::ST_NONE;
                if (head >= held)
                    head = 0;
                for (i = 0; i < held; i++)
                begin
                    idx = head + i;
                    if (idx >= held)
                        idx -= held;
                    age = t - ring_stamps[idx];
                    if (age > rest_limit)
                    begin
                        ring_stamps[idx] = t;
                        r.granted        = ring_keys[idx];
                        r.status         = rrla_pkg::ST_OK;
                        head             = (idx + 1 >= held) ? 0 : idx + 1;
                        break;
                    end
                end
            end
            else
            begin
                slot = find_key(k);
                if (k == '0 || slot < 0)
                    r.status = rrla_pkg::ST_NOT_FOUND;
                else
                    ring_stamps[slot] = (op == rrla_pkg::OP_TOUCH) ? t : '0;
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] got_status,
                                   logic [rrla_pkg::KEY_W-1:0] got_key);
            lease_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d granted_key %h",
                       got_status, got_key);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got_status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
                fail_count++;
            end
            if (got_key !== want.granted)
            begin
                $error("granted_key mismatch: expected %h, actual %h", want.granted, got_key);
                fail_count++;
            end
        endfunction
    endclass

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [rrla_pkg::TIME_W-1:0] cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [1:0]                  operation   = '0;
    logic [rrla_pkg::KEY_W-1:0]  key         = '0;
    logic [rrla_pkg::TIME_W-1:0] now         = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [2:0]                  status;
    logic [rrla_pkg::KEY_W-1:0]  granted_key;

    lease_scoreboard             sb;
    bit                          steady_flow = 1'b0;
    int                          cycle_count = 0;
    logic [rrla_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [rrla_pkg::TIME_W-1:0] clock_ticks = 32'hFFFF_C000;

    round_robin_lease_arbiter_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .key         (key),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .granted_key (granted_key)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("round_robin_lease_arbiter_core verification failed");
            $finish;
        end
    end

    // Caller sits on a rising edge; returns on the edge where the transfer happened.
    task automatic send_request(rrla_pkg::op_t op, logic [rrla_pkg::KEY_W-1:0] k,
                                logic [rrla_pkg::TIME_W-1:0] t);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        now       <= t;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_request(op, k, t);
        if ($urandom_range(0, 63) == 0)
            steady_flow = !steady_flow;
    endtask

    // Hold off until the block has returned everything, then load max_wait.
    task automatic set_rest_limit(logic [rrla_pkg::TIME_W-1:0] limit);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.rest_limit = limit;
    endtask

    task automatic random_request();
        rrla_pkg::op_t               op;
        logic [rrla_pkg::KEY_W-1:0]  k;
        logic [rrla_pkg::TIME_W-1:0] t;
        int                          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = rrla_pkg::OP_GET;
        else if (pick < 60)
            op = rrla_pkg::OP_ADD;
        else if (pick < 80)
            op = rrla_pkg::OP_TOUCH;
        else
            op = rrla_pkg::OP_RELEASE;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 95)
            k = $urandom;
        else
            k = '0;
        // mostly a monotonic clock that wraps, some arbitrary times as noise
        clock_ticks = clock_ticks + $urandom_range(0, 24);
        t = ($urandom_range(0, 9) == 0) ? $urandom : clock_ticks;
        send_request(op, k, t);
    endtask

    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            sb.check_result(status, granted_key);
        end
    end

    initial
    begin : stimulus
        logic [rrla_pkg::TIME_W-1:0] phase_limits [NUM_PHASES];
        int                          p;
        int                          n;
        sb = new();
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'd1;
        key_pool[2] = 32'd2;
        for (n = 3; n < POOL_SIZE; n++)
        begin
            key_pool[n] = $urandom;
            if (key_pool[n] == '0)
                key_pool[n] = 32'h0000_0100 + n;
        end
        phase_limits[0] = 32'd25;
        phase_limits[1] = 32'd0;
        phase_limits[2] = 32'hFFFF_FFFF;
        phase_limits[3] = $urandom_range(1, 100);
        phase_limits[4] = 32'd60;
        phase_limits[5] = $urandom;
        phase_limits[6] = 32'd3;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, max_wait at its reset value
        send_request(rrla_pkg::OP_GET,     32'd0,         32'd0);
        send_request(rrla_pkg::OP_TOUCH,   32'd1,         32'd7);
        send_request(rrla_pkg::OP_RELEASE, 32'd0,         32'd0);
        send_request(rrla_pkg::OP_ADD,     32'd0,         32'd0);
        send_request(rrla_pkg::OP_ADD,     32'hFFFF_FFFF, 32'd0);
        send_request(rrla_pkg::OP_ADD,     32'd1,         32'hFFFF_FFFF);
        send_request(rrla_pkg::OP_ADD,     32'd1,         32'd0);
        send_request(rrla_pkg::OP_TOUCH,   32'd0,         32'd5);
        send_request(rrla_pkg::OP_RELEASE, 32'h8000_0000, 32'd0);
        send_request(rrla_pkg::OP_GET,     32'd0,         32'd0);
        send_request(rrla_pkg::OP_GET,     32'd0,         32'd60);
        send_request(rrla_pkg::OP_GET,     32'hFFFF_FFFF, 32'd61);
        send_request(rrla_pkg::OP_GET,     32'd0,         32'hFFFF_FFFF);
        send_request(rrla_pkg::OP_TOUCH,   32'd1,         32'hFFFF_FFFF);
        send_request(rrla_pkg::OP_RELEASE, 32'hFFFF_FFFF, 32'h0000_3039);
        // age wraps past zero and stays under the limit
        send_request(rrla_pkg::OP_GET,     32'd0,         32'h0000_0030);
        send_request(rrla_pkg::OP_ADD,     32'd2,         32'd0);
        send_request(rrla_pkg::OP_GET,     32'd0,         32'h7FFF_FFFF);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_rest_limit(phase_limits[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("round_robin_lease_arbiter_core verification clean");
        else
            $display("round_robin_lease_arbiter_core verification failed");
        $finish;
    end

endmodule

### files.f
design/rrla_pkg.sv
design/rrla_match.sv
design/rrla_ctrl.sv
design/round_robin_lease_arbiter_core.sv
tb/testbench.sv
